// ===== hw/rtl/mipsenc_pkg.sv =====
package mipsenc_pkg;

  localparam int KindW  = 6;
  localparam int WordW  = 32;
  localparam int RegW   = 5;
  localparam int CodeW  = 6;
  localparam int ImmW   = 16;

  localparam logic [4:0] K_ADD   = 5'd0;
  localparam logic [4:0] K_ADDU  = 5'd1;
  localparam logic [4:0] K_AND   = 5'd2;
  localparam logic [4:0] K_JR    = 5'd3;
  localparam logic [4:0] K_OR    = 5'd4;
  localparam logic [4:0] K_SLT   = 5'd5;
  localparam logic [4:0] K_SLTU  = 5'd6;
  localparam logic [4:0] K_SUB   = 5'd7;
  localparam logic [4:0] K_SUBU  = 5'd8;
  localparam logic [4:0] K_XOR   = 5'd9;
  localparam logic [4:0] K_SLL   = 5'd10;
  localparam logic [4:0] K_SRL   = 5'd11;
  localparam logic [4:0] K_DIV   = 5'd12;
  localparam logic [4:0] K_DIVU  = 5'd13;
  localparam logic [4:0] K_MULT  = 5'd14;
  localparam logic [4:0] K_MULTU = 5'd15;
  localparam logic [4:0] K_MFHI  = 5'd16;
  localparam logic [4:0] K_MFLO  = 5'd17;
  localparam logic [4:0] K_MTHI  = 5'd18;
  localparam logic [4:0] K_MTLO  = 5'd19;
  localparam logic [4:0] K_ADDI  = 5'd20;
  localparam logic [4:0] K_ADDIU = 5'd21;
  localparam logic [4:0] K_ANDI  = 5'd22;
  localparam logic [4:0] K_BEQ   = 5'd23;
  localparam logic [4:0] K_BNE   = 5'd24;
  localparam logic [4:0] K_LW    = 5'd25;
  localparam logic [4:0] K_ORI   = 5'd26;
  localparam logic [4:0] K_XORI  = 5'd27;
  localparam logic [4:0] K_SW    = 5'd28;
  localparam logic [4:0] K_LUI   = 5'd29;
  localparam logic [4:0] K_J     = 5'd30;
  localparam logic [4:0] K_JAL   = 5'd31;

  typedef enum logic [3:0] {
    FMT_NONE,
    FMT_RRR,
    FMT_JR,
    FMT_SH,
    FMT_RSRT,
    FMT_RD,
    FMT_RS,
    FMT_IMM,
    FMT_BR,
    FMT_LUI,
    FMT_JMP
  } fmt_t;

  typedef struct packed {
    fmt_t             fmt;
    logic [CodeW-1:0] code;
  } enc_entry_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [WordW-1:0] arg0;
    logic [WordW-1:0] arg1;
    logic [WordW-1:0] arg2;
    logic [WordW-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [WordW-1:0] out_address;
  } out_item_t;

  function automatic enc_entry_t enc_lookup(input logic [4:0] k);
    enc_entry_t e;
    unique case (k)
      K_ADD:   e = '{FMT_RRR,  6'h20};
      K_ADDU:  e = '{FMT_RRR,  6'h21};
      K_AND:   e = '{FMT_RRR,  6'h24};
      K_JR:    e = '{FMT_JR,   6'h08};
      K_OR:    e = '{FMT_RRR,  6'h25};
      K_SLT:   e = '{FMT_RRR,  6'h2A};
      K_SLTU:  e = '{FMT_RRR,  6'h2B};
      K_SUB:   e = '{FMT_RRR,  6'h22};
      K_SUBU:  e = '{FMT_RRR,  6'h23};
      K_XOR:   e = '{FMT_RRR,  6'h26};
      K_SLL:   e = '{FMT_SH,   6'h00};
      K_SRL:   e = '{FMT_SH,   6'h02};
      K_DIV:   e = '{FMT_RSRT, 6'h1A};
      K_DIVU:  e = '{FMT_RSRT, 6'h1B};
      K_MULT:  e = '{FMT_RSRT, 6'h18};
      K_MULTU: e = '{FMT_RSRT, 6'h19};
      K_MFHI:  e = '{FMT_RD,   6'h10};
      K_MFLO:  e = '{FMT_RD,   6'h12};
      K_MTHI:  e = '{FMT_RS,   6'h11};
      K_MTLO:  e = '{FMT_RS,   6'h13};
      K_ADDI:  e = '{FMT_IMM,  6'h08};
      K_ADDIU: e = '{FMT_IMM,  6'h09};
      K_ANDI:  e = '{FMT_IMM,  6'h0C};
      K_BEQ:   e = '{FMT_BR,   6'h04};
      K_BNE:   e = '{FMT_BR,   6'h05};
      K_LW:    e = '{FMT_IMM,  6'h23};
      K_ORI:   e = '{FMT_IMM,  6'h0D};
      K_XORI:  e = '{FMT_IMM,  6'h0E};
      K_SW:    e = '{FMT_IMM,  6'h2B};
      K_LUI:   e = '{FMT_LUI,  6'h0F};
      K_J:     e = '{FMT_JMP,  6'h02};
      K_JAL:   e = '{FMT_JMP,  6'h03};
    endcase
    return e;
  endfunction

endpackage

// ===== hw/rtl/mipsenc_in_if.sv =====
interface mipsenc_in_if;
  import mipsenc_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [WordW-1:0] arg0;
  logic [WordW-1:0] arg1;
  logic [WordW-1:0] arg2;
  logic [WordW-1:0] address;

  modport source (output valid, kind, arg0, arg1, arg2, address, input ready);
  modport sink   (input valid, kind, arg0, arg1, arg2, address, output ready);
endinterface

// ===== hw/rtl/mipsenc_out_if.sv =====
interface mipsenc_out_if;
  import mipsenc_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] word;
  logic [WordW-1:0] out_address;

  modport source (output valid, word, out_address, input ready);
  modport sink   (input valid, word, out_address, output ready);
endinterface

// ===== hw/rtl/mipsenc_in_stage.sv =====
module mipsenc_in_stage
  import mipsenc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  in_item_t up_item,
  output logic     valid,
  input  logic     down_ready,
  output in_item_t item
);

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= up_item;
    end
  end

endmodule

// ===== hw/rtl/mipsenc_encoder.sv =====
module mipsenc_encoder
  import mipsenc_pkg::*;
(
  input  in_item_t  item,
  output out_item_t result
);

  enc_entry_t        ent;
  logic [RegW-1:0]   r0;
  logic [RegW-1:0]   r1;
  logic [RegW-1:0]   r2;
  logic [ImmW-1:0]   imm1;
  logic [ImmW-1:0]   imm2;
  logic [CodeW-1:0]  code;
  logic [WordW-1:0]  word;

  assign ent  = enc_lookup(item.kind[4:0]);
  assign code = ent.code;
  assign r0   = item.arg0[RegW-1:0];
  assign r1   = item.arg1[RegW-1:0];
  assign r2   = item.arg2[RegW-1:0];
  assign imm1 = item.arg1[ImmW-1:0];
  assign imm2 = item.arg2[ImmW-1:0];

  always_comb begin
    unique case (ent.fmt)
      FMT_RRR:  word = {6'b0, r1, r2, r0, 5'b0, code};
      FMT_JR:   word = {6'b0, r0, 15'b0, code};
      FMT_SH:   word = {6'b0, 5'b0, r1, r0, r2, code};
      FMT_RSRT: word = {6'b0, r0, r1, 10'b0, code};
      FMT_RD:   word = {16'b0, r0, 5'b0, code};
      FMT_RS:   word = {6'b0, r0, 15'b0, code};
      FMT_IMM:  word = {code, r1, r0, imm2};
      FMT_BR:   word = {code, r0, r1, imm2};
      FMT_LUI:  word = {code, 5'b0, r0, imm1};
      FMT_JMP:  word = {code, item.arg0[27:2]};
      default:  word = '0;
    endcase
  end

  // Mnemonic codes above the table encode as a zero word.
  assign result.word        = item.kind[KindW-1] ? '0 : word;
  assign result.out_address = item.address;

endmodule

// ===== hw/rtl/mipsenc_out_stage.sv =====
module mipsenc_out_stage
  import mipsenc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  out_item_t up_item,
  output logic      valid,
  input  logic      down_ready,
  output out_item_t item
);

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= up_item;
    end
  end

endmodule

// ===== hw/rtl/mips_instruction_encoder.sv =====
// An accepted line passes through the input register, then the result register.
// Throughput: one line per cycle while res.ready is high, set by both registers.
// The encoder between the two registers is a single table lookup and field pack.
// Reset (rst, synchronous, active high) empties both registers; there is no
// other state to clear.
module mips_instruction_encoder
  import mipsenc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  mipsenc_in_if.sink    cmd,
  mipsenc_out_if.source res
);

  in_item_t  cmd_item;
  in_item_t  s1_item;
  out_item_t enc_item;
  out_item_t res_item;
  logic      cmd_ready;
  logic      s1_valid;
  logic      s1_ready;
  logic      res_valid;

  assign cmd_item.kind    = cmd.kind;
  assign cmd_item.arg0    = cmd.arg0;
  assign cmd_item.arg1    = cmd.arg1;
  assign cmd_item.arg2    = cmd.arg2;
  assign cmd_item.address = cmd.address;
  assign cmd.ready        = cmd_ready;

  mipsenc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (cmd.valid),
    .up_ready   (cmd_ready),
    .up_item    (cmd_item),
    .valid      (s1_valid),
    .down_ready (s1_ready),
    .item       (s1_item)
  );

  mipsenc_encoder u_encoder (
    .item   (s1_item),
    .result (enc_item)
  );

  mipsenc_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (s1_valid),
    .up_ready   (s1_ready),
    .up_item    (enc_item),
    .valid      (res_valid),
    .down_ready (res.ready),
    .item       (res_item)
  );

  assign res.valid       = res_valid;
  assign res.word        = res_item.word;
  assign res.out_address = res_item.out_address;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid && !s1_valid)
    else $error("Result register not empty after reset.");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res.valid && !res.ready) |-> !cmd.ready)
    else $error("Input taken while both stages are full and stalled.");

  a_transfer_lands: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> s1_valid)
    else $error("Accepted line was not captured.");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ready) |=> res.valid)
    else $error("Encoded line was not registered for output.");
`endif

endmodule
